/* src/sstk_pkg.sv */
// Shared types and constants for the sortable stack core.
`timescale 1ns / 1ps

package sstk_pkg;

    localparam int DEF_STACK_DEPTH = 64;
    localparam int DATA_W          = 32;
    localparam int DEPTH_OUT_W     = 7;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_SORT = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_OVERFLOW  = 2'd1,
        STS_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_GETI = 4'b0010,
        S_SCAN = 4'b0100,
        S_WRI  = 4'b1000
    } t_state;

endpackage

/* src/sortable_stack_core.sv */
// LIFO stack of signed words with in-place exchange sort, memory based.
`timescale 1ns / 1ps

// Channel  Signals                                      Direction
// input    i_in_valid, o_in_stall, i_operation,         into core
//          i_push_value
// output   o_out_valid, i_out_stall, o_popped_value,    out of core
//          o_top_value, o_depth_now, o_is_empty,
//          o_is_full, o_status
//
// Push, pop and no-op are taken while idle; each result goes through the middle stage and
// the output register before it can transfer out. Sort of n >= 2 entries holds the input;
// the single memory read port paces it (one compare per entry above index i per outer step).
// Reset (i_rst_n low, synchronous) empties the stack; memory contents are left as is.
// A stalled output keeps one further result in the middle stage before stalling input.
module sortable_stack_core #(
    parameter int STACK_DEPTH = sstk_pkg::DEF_STACK_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [1:0]                             i_operation,
    input  logic signed [sstk_pkg::DATA_W-1:0]     i_push_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [sstk_pkg::DATA_W-1:0]     o_popped_value,
    output logic signed [sstk_pkg::DATA_W-1:0]     o_top_value,
    output logic [sstk_pkg::DEPTH_OUT_W-1:0]       o_depth_now,
    output logic                                   o_is_empty,
    output logic                                   o_is_full,
    output logic [1:0]                             o_status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int DW = sstk_pkg::DATA_W;
    localparam int OW = sstk_pkg::DEPTH_OUT_W;

    logic [DW-1:0]        r_mem [STACK_DEPTH];
    logic [DW-1:0]        r_rdata;

    sstk_pkg::t_state     r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [DW-1:0]        r_top, n_top;
    logic                 r_top_pend, n_top_pend;
    logic [AW-1:0]        r_si, n_si;
    logic [AW-1:0]        r_sj, n_sj;
    logic [DW-1:0]        r_sv, n_sv;

    logic                 r_s1_valid, n_s1_valid;
    logic [DW-1:0]        r_s1_popped, n_s1_popped;
    sstk_pkg::t_status    r_s1_status, n_s1_status;

    logic                 r_out_valid, n_out_valid;
    logic [DW-1:0]        r_out_popped;
    logic [DW-1:0]        r_out_top;
    logic [CW-1:0]        r_out_count;
    logic                 r_out_full;
    sstk_pkg::t_status    r_out_status;

    logic                 w_we, w_re;
    logic [AW-1:0]        w_waddr, w_raddr;
    logic [DW-1:0]        w_wdata;
    logic [DW-1:0]        w_cur_top;
    logic                 w_full;
    logic                 w_s1_adv;
    logic                 w_in_acc;
    logic                 w_s1_load;
    logic [DW-1:0]        w_s1_popped;
    sstk_pkg::t_status    w_s1_status;
    logic                 w_gt;
    logic [CW+OW-1:0]     w_depth_ext;

    assign w_cur_top = r_top_pend ? r_rdata : r_top;
    assign w_full    = (r_count == CW'(STACK_DEPTH));
    assign w_s1_adv  = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !((r_state == sstk_pkg::S_IDLE) && (!r_s1_valid || w_s1_adv));
    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_gt      = $signed(r_sv) > $signed(r_rdata);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_top       = w_cur_top;
        n_top_pend  = 1'b0;
        n_si        = r_si;
        n_sj        = r_sj;
        n_sv        = r_sv;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_waddr     = r_count[AW-1:0];
        w_raddr     = r_si;
        w_wdata     = i_push_value;
        w_s1_load   = 1'b0;
        w_s1_popped = '0;
        w_s1_status = sstk_pkg::STS_OK;

        unique case (r_state)
            sstk_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    w_s1_load = 1'b1;
                    case (i_operation)
                        sstk_pkg::OP_PUSH: begin
                            if (w_full) begin
                                w_s1_status = sstk_pkg::STS_OVERFLOW;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_count[AW-1:0];
                                w_wdata = i_push_value;
                                n_count = r_count + CW'(1);
                                n_top   = i_push_value;
                            end
                        end
                        sstk_pkg::OP_POP: begin
                            if (r_count == '0) begin
                                w_s1_status = sstk_pkg::STS_UNDERFLOW;
                            end else begin
                                w_s1_popped = w_cur_top;
                                n_count     = r_count - CW'(1);
                                if (r_count >= CW'(2)) begin
                                    w_re       = 1'b1;
                                    w_raddr    = AW'(r_count - CW'(2));
                                    n_top_pend = 1'b1;
                                end
                            end
                        end
                        sstk_pkg::OP_SORT: begin
                            if (r_count >= CW'(2)) begin
                                w_s1_load = 1'b0;
                                w_re      = 1'b1;
                                w_raddr   = '0;
                                n_si      = '0;
                                n_state   = sstk_pkg::S_GETI;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sstk_pkg::S_GETI: begin
                n_sv    = r_rdata;
                w_re    = 1'b1;
                w_raddr = r_si + AW'(1);
                n_sj    = r_si + AW'(1);
                n_state = sstk_pkg::S_SCAN;
            end
            sstk_pkg::S_SCAN: begin
                if (w_gt) begin
                    w_we    = 1'b1;
                    w_waddr = r_sj;
                    w_wdata = r_sv;
                    n_sv    = r_rdata;
                end
                if (CW'(r_sj) + CW'(1) == r_count) begin
                    n_top   = w_gt ? r_sv : r_rdata;
                    n_state = sstk_pkg::S_WRI;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_sj + AW'(1);
                    n_sj    = r_sj + AW'(1);
                end
            end
            sstk_pkg::S_WRI: begin
                w_we    = 1'b1;
                w_waddr = r_si;
                w_wdata = r_sv;
                if (CW'(r_si) + CW'(2) == r_count) begin
                    w_s1_load = 1'b1;
                    n_state   = sstk_pkg::S_IDLE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_si + AW'(1);
                    n_si    = r_si + AW'(1);
                    n_state = sstk_pkg::S_GETI;
                end
            end
            default: begin
                n_state = sstk_pkg::S_IDLE;
            end
        endcase

        n_s1_valid  = (r_s1_valid && !w_s1_adv) || w_s1_load;
        n_s1_popped = w_s1_load ? w_s1_popped : r_s1_popped;
        n_s1_status = w_s1_load ? w_s1_status : r_s1_status;
        n_out_valid = w_s1_adv || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sstk_pkg::S_IDLE;
            r_count     <= '0;
            r_top_pend  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_top_pend  <= n_top_pend;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top       <= n_top;
        r_si        <= n_si;
        r_sj        <= n_sj;
        r_sv        <= n_sv;
        r_s1_popped <= n_s1_popped;
        r_s1_status <= n_s1_status;
        if (w_s1_adv) begin
            r_out_popped <= r_s1_popped;
            r_out_top    <= (r_count == '0) ? '0 : w_cur_top;
            r_out_count  <= r_count;
            r_out_full   <= w_full;
            r_out_status <= r_s1_status;
        end
    end

    assign w_depth_ext    = {{OW{1'b0}}, r_out_count};
    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_out_popped;
    assign o_top_value    = r_out_top;
    assign o_depth_now    = w_depth_ext[OW-1:0];
    assign o_is_empty     = (r_out_count == '0);
    assign o_is_full      = r_out_full;
    assign o_status       = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("entry count above stack depth");

    a_sort_s1_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != sstk_pkg::S_IDLE) |-> !r_s1_valid)
        else $error("middle stage busy during sort");

    a_pend_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_top_pend) |-> $past(w_in_acc && (i_operation == sstk_pkg::OP_POP)))
        else $error("top refill without a pop");

    a_empty_top_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |-> (o_top_value == '0))
        else $error("nonzero top on empty stack");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for sortable_stack_core: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_top;

    localparam int          DW          = sstk_pkg::DATA_W;
    localparam int          OW          = sstk_pkg::DEPTH_OUT_W;
    localparam int          STK_N       = sstk_pkg::DEF_STACK_DEPTH;
    localparam logic [1:0]  OP_NOP      = 2'd3;
    localparam int          RAND_ITEMS  = 1130;
    localparam int          HOLD_START  = 300;
    localparam int          HOLD_CYCLES = 400;
    localparam int          TAIL_CYCLES = 20;
    localparam int          MAX_REPORTS = 10;

    localparam logic signed [DW-1:0] W_MIN = 32'sh8000_0000;
    localparam logic signed [DW-1:0] W_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic signed [DW-1:0]  popped;
        logic signed [DW-1:0]  top;
        logic [OW-1:0]         depth;
        logic                  empty;
        logic                  full;
        logic [1:0]            status;
    } t_stack_result;

    typedef struct packed {
        logic [1:0]            op;
        logic signed [DW-1:0]  val;
        logic                  typed;
        t_stack_result         res;
    } t_stim_row;

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_in_valid   = 1'b0;
    logic                      o_in_stall;
    logic [1:0]                i_operation  = sstk_pkg::OP_PUSH;
    logic signed [DW-1:0]      i_push_value = '0;
    logic                      o_out_valid;
    logic                      i_out_stall  = 1'b0;
    logic signed [DW-1:0]      o_popped_value;
    logic signed [DW-1:0]      o_top_value;
    logic [OW-1:0]             o_depth_now;
    logic                      o_is_empty;
    logic                      o_is_full;
    logic [1:0]                o_status;

    sortable_stack_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_push_value   (i_push_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_popped_value (o_popped_value),
        .o_top_value    (o_top_value),
        .o_depth_now    (o_depth_now),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full),
        .o_status       (o_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow copy of the stack
    logic signed [DW-1:0]  stk_mem [STK_N];
    int                    stk_cnt = 0;

    t_stack_result  exp_q [$];
    t_stim_row      dir_q [$];

    int  fails      = 0;
    int  n_checked  = 0;
    int  n_push     = 0;
    int  n_pop      = 0;
    int  n_sort     = 0;
    int  n_nop      = 0;
    int  n_ovf      = 0;
    int  n_unf      = 0;
    int  peak_depth = 0;
    int  rand_sent  = 0;
    bit  hold_off   = 1'b0;

    function automatic t_stack_result apply_op(input logic [1:0] op,
                                               input logic signed [DW-1:0] val);
        t_stack_result         r;
        logic signed [DW-1:0]  t;
        r = '0;
        case (op)
            sstk_pkg::OP_PUSH: begin
                if (stk_cnt >= STK_N) begin
                    r.status = sstk_pkg::STS_OVERFLOW;
                end else begin
                    stk_mem[stk_cnt] = val;
                    stk_cnt++;
                end
            end
            sstk_pkg::OP_POP: begin
                if (stk_cnt == 0) begin
                    r.status = sstk_pkg::STS_UNDERFLOW;
                end else begin
                    stk_cnt--;
                    r.popped = stk_mem[stk_cnt];
                end
            end
            sstk_pkg::OP_SORT: begin
                for (int i = 0; i + 1 < stk_cnt; i++) begin
                    for (int j = i + 1; j < stk_cnt; j++) begin
                        if (stk_mem[i] > stk_mem[j]) begin
                            t          = stk_mem[i];
                            stk_mem[i] = stk_mem[j];
                            stk_mem[j] = t;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.top   = (stk_cnt == 0) ? '0 : stk_mem[stk_cnt-1];
        r.depth = OW'(stk_cnt);
        r.empty = (stk_cnt == 0);
        r.full  = (stk_cnt >= STK_N);
        return r;
    endfunction

    function automatic t_stack_result mk_exp(input logic signed [DW-1:0] popped,
                                             input logic signed [DW-1:0] top,
                                             input int depth, input bit empty,
                                             input bit full, input logic [1:0] st);
        t_stack_result r;
        r.popped = popped;
        r.top    = top;
        r.depth  = OW'(depth);
        r.empty  = empty;
        r.full   = full;
        r.status = st;
        return r;
    endfunction

    function automatic t_stim_row mk_row(input logic [1:0] op,
                                         input logic signed [DW-1:0] val,
                                         input bit typed, input t_stack_result res);
        t_stim_row s;
        s.op    = op;
        s.val   = val;
        s.typed = typed;
        s.res   = res;
        return s;
    endfunction

    function automatic logic signed [DW-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return W_MIN;
            1:       return W_MAX;
            2:       return '0;
            3:       return -1;
            4, 5:    return $signed($urandom_range(0, 15)) - 8;
            default: return $signed($urandom());
        endcase
    endfunction

    // mode 0 fills, mode 1 drains, mode 2 mixes
    function automatic logic [1:0] pick_op(input int mode);
        int r;
        int lim_push, lim_pop, lim_sort;
        r = $urandom_range(0, 99);
        case (mode)
            0:       begin lim_push = 75; lim_pop = 90; lim_sort = 95; end
            1:       begin lim_push = 20; lim_pop = 90; lim_sort = 95; end
            default: begin lim_push = 47; lim_pop = 91; lim_sort = 96; end
        endcase
        if (r < lim_push)      return sstk_pkg::OP_PUSH;
        else if (r < lim_pop)  return sstk_pkg::OP_POP;
        else if (r < lim_sort) return sstk_pkg::OP_SORT;
        else                   return OP_NOP;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic signed [DW-1:0] val,
                             input int gap, input bit typed, input t_stack_result typed_res);
        t_stack_result pred;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_push_value <= val;
        do @(posedge i_clk); while (o_in_stall);
        pred = apply_op(op, val);
        exp_q.push_back(typed ? typed_res : pred);
        case (op)
            sstk_pkg::OP_PUSH: n_push++;
            sstk_pkg::OP_POP:  n_pop++;
            sstk_pkg::OP_SORT: n_sort++;
            default:           n_nop++;
        endcase
        if (pred.status == sstk_pkg::STS_OVERFLOW)  n_ovf++;
        if (pred.status == sstk_pkg::STS_UNDERFLOW) n_unf++;
        if (stk_cnt > peak_depth) peak_depth = stk_cnt;
    endtask

    // stimulus
    initial begin
        int          mode;
        int          blen;
        bit          tx_nogap;
        logic [1:0]  op;
        t_stim_row   row;

        dir_q.push_back(mk_row(sstk_pkg::OP_POP, '0, 1,
                               mk_exp(0, 0, 0, 1, 0, sstk_pkg::STS_UNDERFLOW)));
        dir_q.push_back(mk_row(sstk_pkg::OP_SORT, '0, 1,
                               mk_exp(0, 0, 0, 1, 0, sstk_pkg::STS_OK)));
        dir_q.push_back(mk_row(OP_NOP, -1, 1,
                               mk_exp(0, 0, 0, 1, 0, sstk_pkg::STS_OK)));
        dir_q.push_back(mk_row(sstk_pkg::OP_PUSH, W_MIN, 1,
                               mk_exp(0, W_MIN, 1, 0, 0, sstk_pkg::STS_OK)));
        dir_q.push_back(mk_row(sstk_pkg::OP_SORT, W_MAX, 1,
                               mk_exp(0, W_MIN, 1, 0, 0, sstk_pkg::STS_OK)));
        dir_q.push_back(mk_row(sstk_pkg::OP_PUSH, W_MAX, 1,
                               mk_exp(0, W_MAX, 2, 0, 0, sstk_pkg::STS_OK)));
        dir_q.push_back(mk_row(sstk_pkg::OP_POP, '0, 1,
                               mk_exp(W_MAX, W_MIN, 1, 0, 0, sstk_pkg::STS_OK)));
        dir_q.push_back(mk_row(sstk_pkg::OP_PUSH, W_MAX, 1,
                               mk_exp(0, W_MAX, 2, 0, 0, sstk_pkg::STS_OK)));
        dir_q.push_back(mk_row(sstk_pkg::OP_PUSH, '0, 0, '0));
        dir_q.push_back(mk_row(sstk_pkg::OP_PUSH, -1, 0, '0));
        dir_q.push_back(mk_row(sstk_pkg::OP_PUSH, 5, 0, '0));
        dir_q.push_back(mk_row(sstk_pkg::OP_PUSH, 5, 0, '0));
        dir_q.push_back(mk_row(sstk_pkg::OP_PUSH, -7, 0, '0));
        dir_q.push_back(mk_row(sstk_pkg::OP_PUSH, 32'sh5555_5555, 0, '0));
        dir_q.push_back(mk_row(sstk_pkg::OP_PUSH, 32'shaaaa_aaaa, 0, '0));
        dir_q.push_back(mk_row(sstk_pkg::OP_SORT, '0, 0, '0));
        dir_q.push_back(mk_row(OP_NOP, -1, 0, '0));
        dir_q.push_back(mk_row(sstk_pkg::OP_POP, '0, 0, '0));
        dir_q.push_back(mk_row(sstk_pkg::OP_POP, '0, 0, '0));
        dir_q.push_back(mk_row(sstk_pkg::OP_PUSH, W_MIN, 0, '0));
        dir_q.push_back(mk_row(sstk_pkg::OP_SORT, '0, 0, '0));
        dir_q.push_back(mk_row(sstk_pkg::OP_POP, '0, 0, '0));
        dir_q.push_back(mk_row(sstk_pkg::OP_POP, '0, 0, '0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_q[k]) begin
            row = dir_q[k];
            send_item(row.op, row.val, $urandom_range(0, 3), row.typed, row.res);
        end

        while (rand_sent < RAND_ITEMS) begin
            mode     = $urandom_range(0, 2);
            blen     = $urandom_range(16, 80);
            tx_nogap = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < blen && rand_sent < RAND_ITEMS; k++) begin
                op = pick_op(mode);
                send_item(op, rand_word(), tx_nogap ? 0 : $urandom_range(0, 12), 1'b0, '0);
                rand_sent++;
            end
        end
        i_in_valid <= 1'b0;

        while (exp_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        fails += exp_q.size();

        $display("transfers in: %0d (push %0d, pop %0d, sort %0d, unused op %0d)",
                 n_push + n_pop + n_sort + n_nop, n_push, n_pop, n_sort, n_nop);
        $display("results checked %0d, overflows %0d, underflows %0d, peak depth %0d, failures %0d",
                 n_checked, n_ovf, n_unf, peak_depth, fails);
        if (fails == 0) begin
            $display("[sortable_stack_core] OK");
        end else begin
            $display("[sortable_stack_core] ERROR");
        end
        $finish;
    end

    // result side: random stalls, checks each transfer out
    initial begin
        int             w;
        int             rx_cnt;
        bit             rx_nogap;
        t_stack_result  act;
        t_stack_result  e;

        rx_cnt   = 0;
        rx_nogap = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_cnt % 40 == 0) rx_nogap = ($urandom_range(0, 3) == 0);
            w = rx_nogap ? 0 : $urandom_range(0, 12);
            if (w > 0 || hold_off) begin
                i_out_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
                while (hold_off) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            rx_cnt++;
            act.popped = o_popped_value;
            act.top    = o_top_value;
            act.depth  = o_depth_now;
            act.empty  = o_is_empty;
            act.full   = o_is_full;
            act.status = o_status;
            if (exp_q.size() == 0) begin
                fails++;
                if (fails <= MAX_REPORTS)
                    $display("unexpected result: pop=%0d top=%0d depth=%0d e=%0b f=%0b st=%0d",
                             act.popped, act.top, act.depth, act.empty, act.full, act.status);
            end else begin
                e = exp_q.pop_front();
                n_checked++;
                if (act !== e) begin
                    fails++;
                    if (fails <= MAX_REPORTS) begin
                        $display("mismatch at result %0d:", n_checked);
                        $display("  exp pop=%0d top=%0d depth=%0d e=%0b f=%0b st=%0d",
                                 e.popped, e.top, e.depth, e.empty, e.full, e.status);
                        $display("  got pop=%0d top=%0d depth=%0d e=%0b f=%0b st=%0d",
                                 act.popped, act.top, act.depth, act.empty, act.full,
                                 act.status);
                    end
                end
            end
        end
    end

    // long output hold-off so the core backs up and stalls its input
    initial begin
        wait (rand_sent >= HOLD_START);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #18_000_000;
        $display("timeout: %0d results still expected", exp_q.size());
        $display("[sortable_stack_core] ERROR");
        $finish;
    end

endmodule
